>>> design/fcs_pkg.sv
// fcs_pkg: types, command codes and the ID/CFI table for the flash command sequencer.
// No dependencies; imported by every module of the block.
package fcs_pkg;

   localparam int ADDR_BITS = 21;

   typedef logic [ADDR_BITS-1:0] addr_type;

   typedef enum logic [0:0] {
      FUNC_READ  = 1'b0,
      FUNC_WRITE = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_READ   = 3'd1,
      ACT_ID     = 3'd2,
      ACT_PROG   = 3'd3,
      ACT_CHIP   = 3'd4,
      ACT_SECTOR = 3'd5,
      ACT_BLOCK  = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      MODE_READ_ARRAY = 2'd0,
      MODE_PROG_ARMED = 2'd1,
      MODE_SW_ID      = 2'd2,
      MODE_CFI        = 2'd3
   } cmd_mode_type;

   typedef enum logic [2:0] {
      CYC0 = 3'd0,
      CYC1 = 3'd1,
      CYC2 = 3'd2,
      CYC3 = 3'd3,
      CYC4 = 3'd4,
      CYC5 = 3'd5
   } unlock_type;

   typedef struct packed {
      func_type   func;
      addr_type   addr;
      logic [7:0] wdata;
   } req_type;

   typedef struct packed {
      action_type action;
      addr_type   target_addr;
      logic [7:0] data_out;
   } rsp_type;

   localparam addr_type CMD_ADDR1   = ADDR_BITS'('h5555);
   localparam addr_type CMD_ADDR2   = ADDR_BITS'('h2aaa);
   localparam addr_type SECTOR_MASK = ~ADDR_BITS'('hfff);
   localparam addr_type BLOCK_MASK  = ~ADDR_BITS'('hffff);

   localparam logic [7:0] CMD_UNLOCK1 = 8'haa;
   localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
   localparam logic [7:0] CMD_PROGRAM = 8'ha0;
   localparam logic [7:0] CMD_ERASE   = 8'h80;
   localparam logic [7:0] CMD_SW_ID   = 8'h90;
   localparam logic [7:0] CMD_CFI     = 8'h98;
   localparam logic [7:0] CMD_RESET   = 8'hf0;
   localparam logic [7:0] CMD_CHIP    = 8'h10;
   localparam logic [7:0] CMD_SECTOR  = 8'h30;
   localparam logic [7:0] CMD_BLOCK   = 8'h50;

   localparam int ID_TABLE_LEN = 53;

   localparam logic [7:0] ID_TABLE [ID_TABLE_LEN] = '{
      8'hbf, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h51, 8'h52, 8'h59, 8'h01, 8'h07, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h27, 8'h36, 8'h00, 8'h00, 8'h04,
      8'h00, 8'h04, 8'h06, 8'h01, 8'h00, 8'h01, 8'h01, 8'h15,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'hff, 8'h01, 8'h10,
      8'h00, 8'h1f, 8'h00, 8'h00, 8'h01
   };

   localparam int ID_IDX_BITS = $clog2(ID_TABLE_LEN);

   // ID/CFI byte; zero past the end of the table
   function automatic logic [7:0] id_byte(input addr_type a);
      logic [7:0] b;
      b = 8'h00;
      if (a < addr_type'(ID_TABLE_LEN)) begin
         b = ID_TABLE[a[ID_IDX_BITS-1:0]];
      end
      return b;
   endfunction

endpackage

>>> design/fcs_cmd_fsm.sv
// fcs_cmd_fsm: mode and unlock-cycle state machine plus per-access result decode.
// Depends on fcs_pkg.
module fcs_cmd_fsm
   import fcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   output rsp_type result
);

   cmd_mode_type mode_ff, mode_in;
   unlock_type   cyc_ff, cyc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_READ_ARRAY;
         cyc_ff  <= CYC0;
      end else if (step) begin
         mode_ff <= mode_in;
         cyc_ff  <= cyc_in;
      end
   end

   always_comb begin
      mode_in            = mode_ff;
      cyc_in             = cyc_ff;
      result.action      = ACT_NONE;
      result.target_addr = '0;
      result.data_out    = 8'h00;

      if (item.func == FUNC_READ) begin
         result.target_addr = item.addr;
         if (mode_ff == MODE_READ_ARRAY || mode_ff == MODE_PROG_ARMED) begin
            result.action = ACT_READ;
         end else begin
            result.action   = ACT_ID;
            result.data_out = id_byte(item.addr);
         end
      end else begin
         unique case (cyc_ff)
            CYC0: begin
               if (item.addr == CMD_ADDR1 && item.wdata == CMD_UNLOCK1) begin
                  cyc_in = CYC1;
               end else if (item.wdata == CMD_RESET) begin
                  mode_in = MODE_READ_ARRAY;
               end
            end
            CYC1, CYC4: begin
               if (item.addr == CMD_ADDR2 && item.wdata == CMD_UNLOCK2) begin
                  cyc_in = (cyc_ff == CYC1) ? CYC2 : CYC5;
               end
            end
            CYC2: begin
               if (item.addr == CMD_ADDR1) begin
                  priority if (item.wdata == CMD_PROGRAM) begin
                     mode_in = MODE_PROG_ARMED;
                     cyc_in  = CYC3;
                  end else if (item.wdata == CMD_ERASE) begin
                     cyc_in = CYC3;
                  end else if (item.wdata == CMD_SW_ID) begin
                     mode_in = MODE_SW_ID;
                     cyc_in  = CYC0;
                  end else if (item.wdata == CMD_CFI) begin
                     mode_in = MODE_CFI;
                     cyc_in  = CYC0;
                  end else if (item.wdata == CMD_RESET) begin
                     mode_in = MODE_READ_ARRAY;
                     cyc_in  = CYC0;
                  end else begin
                     cyc_in = cyc_ff;
                  end
               end
            end
            CYC3: begin
               if (mode_ff == MODE_PROG_ARMED) begin
                  result.action      = ACT_PROG;
                  result.target_addr = item.addr;
                  result.data_out    = item.wdata;
                  mode_in            = MODE_READ_ARRAY;
                  cyc_in             = CYC0;
               end else if (item.addr == CMD_ADDR1 && item.wdata == CMD_UNLOCK1) begin
                  cyc_in = CYC4;
               end
            end
            CYC5: begin
               // chip erase needs the command address; sector/block take any
               if (item.wdata == CMD_CHIP) begin
                  if (item.addr == CMD_ADDR1) begin
                     result.action = ACT_CHIP;
                  end
               end else if (item.wdata == CMD_SECTOR) begin
                  result.action      = ACT_SECTOR;
                  result.target_addr = item.addr & SECTOR_MASK;
               end else if (item.wdata == CMD_BLOCK) begin
                  result.action      = ACT_BLOCK;
                  result.target_addr = item.addr & BLOCK_MASK;
               end
               mode_in = MODE_READ_ARRAY;
               cyc_in  = CYC0;
            end
            default: begin
               cyc_in = CYC0;
            end
         endcase
      end
   end

endmodule

>>> design/flash_command_sequencer.sv
// Parallel NOR flash command interface: one bus access in, one result out per item.
// Accepts an item every cycle while req_stall is low; each result passes through the
// input register, command decode and result register. Stalls on the result side hold the
// result register and, once both registers are full, raise req_stall in the same cycle.
// Reads in read-array or program-armed mode ask for an array read; in ID or CFI mode they
// return the built-in table byte (0 past its end). Writes walk the JEDEC unlock cycles and
// issue byte program, chip, sector (4 KiB) or block (64 KiB) erase. No memory, no clearing
// pass: the block is ready right after reset. Depends on fcs_pkg and fcs_cmd_fsm.
module flash_command_sequencer
   import fcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,

   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,

   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;

   // result register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;

   logic    advance;    // decode stage hands its item to the result register
   logic    step;       // an item is decoded this cycle, state moves
   rsp_type decoded;

   // result register can load when empty or being drained
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   // input register is free when empty or moving on
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in  = req_valid ? 1'b1 : (in_valid_ff && !advance);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         // a new item only arrives when req_stall is low
         in_valid_ff  <= req_stall ? in_valid_ff : in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_item;
      end
      if (step) begin
         out_item_ff <= decoded;
      end
   end

   // command state machine and result decode
   fcs_cmd_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .result (decoded)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

>>> design/fcs_checker.sv
// fcs_checker: port-level checks for flash_command_sequencer, attached by bind.
// Depends on fcs_pkg.
module fcs_checker
   import fcs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_item,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_item
);

   // stalled access holds on the input side
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_item))
      else $error("access changed while stalled");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // input side only backs up when the result side is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a stalled result");

   a_none_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.action == ACT_NONE || rsp_item.action == ACT_CHIP)
      |-> rsp_item.target_addr == '0 && rsp_item.data_out == 8'h00)
      else $error("no-op or chip erase with nonzero address or data");

   a_erase_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.action == ACT_SECTOR || rsp_item.action == ACT_BLOCK)
      |-> rsp_item.target_addr[11:0] == 12'h000 && rsp_item.data_out == 8'h00)
      else $error("erase address not aligned");

endmodule

bind flash_command_sequencer fcs_checker u_fcs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
